// ===== design/ccrs_pkg.sv =====
// ----------------------------------------------------------------------------
// ccrs_pkg: shared types and constants of the constant and register store
// Word formats, configuration codes and store geometry.
// ----------------------------------------------------------------------------
package ccrs_pkg;

  localparam int CONST_ENTRIES = 32;
  localparam int REG_ENTRIES   = 8;
  localparam int CONST_AW      = $clog2(CONST_ENTRIES);
  localparam int REG_AW        = 3;

  localparam logic [63:0] REG_RESET = {16{4'hC}};

  localparam logic [15:0] CF_MASK  = 16'h10D0;
  localparam logic [15:0] CF_MATCH = 16'h00C0;
  localparam logic [15:0] RS_MASK0 = 16'hFF0F;
  localparam logic [15:0] RS_MASK1 = 16'hFFEF;
  localparam logic [15:0] RS_MATCH = 16'h0A0F;

  localparam logic [3:0] FN_NONE_A = 4'h0;
  localparam logic [3:0] FN_NONE_B = 4'h8;
  localparam logic [3:0] FN_NONE_C = 4'hA;

  typedef enum logic [1:0] {
    ACT_OTHER  = 2'd0,
    ACT_DRIVE  = 2'd1,
    ACT_SAMPLE = 2'd2,
    ACT_LOAD   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CFG_STORE_MODE  = 3'd0,
    CFG_CONST_FIRST = 3'd1,
    CFG_CONST_LIMIT = 3'd2,
    CFG_REG_FIRST   = 3'd3,
    CFG_REG_LIMIT   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] instr_word;
    logic [15:0] ext_word;
    logic [63:0] io_in;
    logic [4:0]  rom_index;
  } in_word_t;

  typedef struct packed {
    logic [63:0] io_out;
    logic        io_driven;
  } out_word_t;

  typedef struct packed {
    logic       store_mode;
    logic [6:0] const_first;
    logic [7:0] const_limit;
    logic [5:0] reg_first;
    logic [6:0] reg_limit;
  } cfg_t;

  typedef struct packed {
    logic                rom_we;
    logic [CONST_AW-1:0] rom_waddr;
    logic                reg_we;
    logic [REG_AW-1:0]   reg_waddr;
    logic [CONST_AW-1:0] rom_raddr;
    logic [REG_AW-1:0]   reg_raddr;
  } store_req_t;

endpackage

// ===== design/ccrs_store.sv =====
// ----------------------------------------------------------------------------
// ccrs_store: constant ROM and data register store
// Flop arrays with one write and one read port each; the register store
// resets to every nibble 0xC, the ROM holds whatever was loaded.
// ----------------------------------------------------------------------------
module ccrs_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ccrs_pkg::store_req_t req_i,
  input  logic [63:0]         wdata_i,
  output logic [63:0]         rom_rdata_o,
  output logic [63:0]         reg_rdata_o
);
  import ccrs_pkg::*;

  logic [63:0] rom_q [CONST_ENTRIES];
  logic [63:0] reg_q [REG_ENTRIES];

  always_ff @(posedge clk_i) begin
    if (req_i.rom_we) begin
      rom_q[req_i.rom_waddr] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_ENTRIES; i++) begin
        reg_q[i] <= REG_RESET;
      end
    end else if (req_i.reg_we) begin
      reg_q[req_i.reg_waddr] <= wdata_i;
    end
  end

  assign rom_rdata_o = rom_q[req_i.rom_raddr];
  assign reg_rdata_o = reg_q[req_i.reg_raddr];

endmodule

// ===== design/ccrs_slot.sv =====
// ----------------------------------------------------------------------------
// ccrs_slot: bus slot decoder and fetch queues
// Decodes one slot, advances the constant and register queues and forms
// the IO result; store accesses go out as one request word.
// ----------------------------------------------------------------------------
module ccrs_slot (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  ccrs_pkg::in_word_t   item_i,
  input  ccrs_pkg::cfg_t       cfg_i,
  input  logic [63:0]          rom_rdata_i,
  input  logic [63:0]          reg_rdata_i,
  output ccrs_pkg::store_req_t req_o,
  output ccrs_pkg::out_word_t  res_o
);
  import ccrs_pkg::*;

  logic [15:0] cp_q, cp_d;
  logic [23:0] rp_q, rp_d;

  logic [3:0]  fn;
  logic        c_hit;
  logic [6:0]  c_addr;
  logic        c_take;
  logic [6:0]  c_off;
  logic        r_hit;
  logic [3:0]  r_num;
  logic        r_take;
  logic [2:0]  r_off;
  logic        sto_due;
  logic        rom_ok;
  logic        reg_ok;
  logic        sto_ok;
  logic        load_ok;

  assign fn     = item_i.instr_word[11:8];
  assign c_hit  = ((item_i.instr_word & CF_MASK) == CF_MATCH) && (fn != FN_NONE_A)
                  && (fn != FN_NONE_B) && (fn != FN_NONE_C);
  assign c_addr = {item_i.ext_word[10:7], item_i.ext_word[5:3]};
  assign c_take = c_hit && (c_addr >= cfg_i.const_first)
                  && ({1'b0, c_addr} < cfg_i.const_limit);
  assign c_off  = c_addr - cfg_i.const_first;

  always_comb begin
    if (!cfg_i.store_mode) begin
      r_hit = (item_i.instr_word & RS_MASK0) == RS_MATCH;
      r_num = {1'b0, item_i.instr_word[7:5]};
    end else begin
      r_hit = (item_i.instr_word & RS_MASK1) == RS_MATCH;
      r_num = rp_q[4] ? 4'h0 : item_i.io_in[3:0];
    end
  end

  assign r_take  = r_hit && ({2'b00, r_num} >= cfg_i.reg_first)
                   && ({3'b000, r_num} < cfg_i.reg_limit);
  assign r_off   = r_num[2:0] - cfg_i.reg_first[2:0];
  assign sto_due = rp_q[0] && !rp_q[4];

  assign rom_ok  = {1'b0, cp_q[14:8]} < 8'(CONST_ENTRIES);
  assign reg_ok  = {1'b0, rp_q[15:13]} < 4'(REG_ENTRIES);
  assign sto_ok  = {1'b0, rp_q[7:5]} < 4'(REG_ENTRIES);
  assign load_ok = {1'b0, item_i.rom_index} < 6'(CONST_ENTRIES);

  always_comb begin
    cp_d            = cp_q;
    rp_d            = rp_q;
    res_o.io_out    = item_i.io_in;
    res_o.io_driven = 1'b0;
    req_o.rom_we    = 1'b0;
    req_o.rom_waddr = item_i.rom_index[CONST_AW-1:0];
    req_o.reg_we    = 1'b0;
    req_o.reg_waddr = rp_q[7:5];
    req_o.rom_raddr = cp_q[8 +: CONST_AW];
    req_o.reg_raddr = rp_q[15:13];
    unique case (action_e'(item_i.action))
      ACT_DRIVE: begin
        cp_d = {8'h00, cp_q[15:8]};
        rp_d = {8'h00, rp_q[23:8]};
        if (cp_q[15]) begin
          res_o.io_driven = 1'b1;
          res_o.io_out    = rom_ok ? rom_rdata_i : 64'h0;
        end
        if (rp_q[12]) begin
          res_o.io_driven = 1'b1;
          res_o.io_out    = reg_ok ? reg_rdata_i : 64'h0;
        end
      end
      ACT_SAMPLE: begin
        if (c_take) begin
          cp_d[15:8] = cp_q[15:8] | {1'b1, c_off};
        end
        req_o.reg_we = en_i && sto_due && sto_ok;
        if (r_take) begin
          rp_d[23:16] = rp_q[23:16] | {r_off, item_i.instr_word[4:0]};
        end
      end
      ACT_LOAD: begin
        req_o.rom_we = en_i && load_ok;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_q <= '0;
      rp_q <= '0;
    end else if (en_i) begin
      cp_q <= cp_d;
      rp_q <= rp_d;
    end
  end

endmodule

// ===== design/calculator_constant_and_register_store_unit.sv =====
// ----------------------------------------------------------------------------
// calculator_constant_and_register_store_unit: constant ROM and register store
// Bus slot engine: input register, slot decode with store access, result
// register, plus the configuration registers.
//
//   channel   handshake                   payload
//   in        in_valid_i / in_ready_o     in_word_i   (ccrs_pkg::in_word_t)
//   out       out_valid_o / out_ready_i   out_word_o  (ccrs_pkg::out_word_t)
//   cfg       cfg_we_i                    cfg_idx_i, cfg_data_i
//
// One word per cycle while the result is not stalled; a taken word passes
// through the input register, the combinational decode and store access,
// and the result register.
// A stalled result holds the input register, which then blocks new words.
// Reset empties the queues, restores the default configuration and fills
// the register store with 0xC nibbles; ROM contents stay unknown until loaded.
// ----------------------------------------------------------------------------
module calculator_constant_and_register_store_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ccrs_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ccrs_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [7:0]          cfg_data_i
);
  import ccrs_pkg::*;

  logic       s1_valid_q;
  in_word_t   s1_q;
  logic       out_valid_q;
  out_word_t  out_q;
  out_word_t  res;
  logic       adv;
  cfg_t       cfg_q;
  store_req_t req;
  logic [63:0] rom_rdata;
  logic [63:0] reg_rdata;

  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.store_mode  <= 1'b0;
      cfg_q.const_first <= 7'd0;
      cfg_q.const_limit <= 8'd16;
      cfg_q.reg_first   <= 6'd0;
      cfg_q.reg_limit   <= 7'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STORE_MODE:  cfg_q.store_mode  <= cfg_data_i[0];
        CFG_CONST_FIRST: cfg_q.const_first <= cfg_data_i[6:0];
        CFG_CONST_LIMIT: cfg_q.const_limit <= cfg_data_i;
        CFG_REG_FIRST:   cfg_q.reg_first   <= cfg_data_i[5:0];
        CFG_REG_LIMIT:   cfg_q.reg_limit   <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  ccrs_slot u_slot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .item_i      (s1_q),
    .cfg_i       (cfg_q),
    .rom_rdata_i (rom_rdata),
    .reg_rdata_i (reg_rdata),
    .req_o       (req),
    .res_o       (res)
  );

  ccrs_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .wdata_i     (s1_q.io_in),
    .rom_rdata_o (rom_rdata),
    .reg_rdata_o (reg_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !adv)
    else $error("slot advanced into a stalled result register");

  a_drive_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && res.io_driven |-> s1_q.action == ACT_DRIVE)
    else $error("IO driven outside a drive slot");

  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_q.io_driven || (out_q.io_out == $past(s1_q.io_in)))
    else $error("undriven slot altered the IO word");

  a_block_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input blocked without a stalled result");

endmodule
